[rtl/ogp_pkg.sv]
package ogp_pkg;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int PIX_W   = 10;
    localparam int DEPTH_W = 16;
    localparam int BYTE_W  = 8;
    localparam int MAPI_W  = 18;
    localparam int VAL_W   = 8;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    // datapath widths
    localparam int ANG_W   = 27;
    localparam int XY_W    = 33;
    localparam int TRIG_W  = 32;
    localparam int DVD_W   = 34;
    localparam int DVS_W   = 11;
    localparam int PROD_W  = 66;
    localparam int OFF_W   = 18;
    localparam int POS_W   = 20;
    localparam int SCALE_W = 32;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam int CORDIC_STEPS = 16;

    // request selector
    localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    // stored cell codes
    localparam logic [1:0] CODE_UNKNOWN  = 2'd0;
    localparam logic [1:0] CODE_FREE     = 2'd1;
    localparam logic [1:0] CODE_OCCUPIED = 2'd2;

    // register indexes
    localparam logic [2:0] REG_FOVH  = 3'd0;
    localparam logic [2:0] REG_FOVV  = 3'd1;
    localparam logic [2:0] REG_PITCH = 3'd2;
    localparam logic [2:0] REG_COLS  = 3'd3;
    localparam logic [2:0] REG_ROWS  = 3'd4;
    localparam logic [2:0] REG_CPM   = 3'd5;
    localparam logic [2:0] REG_MAXD  = 3'd6;

    typedef struct packed {
        logic [7:0]         fovh;
        logic [7:0]         fovv;
        logic [6:0]         pitch;
        logic [PIX_W-1:0]   cols;
        logic [PIX_W-1:0]   rows;
        logic [15:0]        cpm;
        logic [DEPTH_W-1:0] max_depth;
    } cfg_t;

    typedef struct packed {
        logic       clear;
        logic       wr_en;
        logic [1:0] wr_code;
        logic       rd_en;
    } grid_cmd_t;

    typedef enum logic [3:0] {
        ST_CLR_GO,
        ST_CLEAR,
        ST_IDLE,
        ST_TH_DIV,
        ST_PH_DIV,
        ST_PH_COR,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_MUL5,
        ST_WRITE,
        ST_RD_LAT,
        ST_RD_OUT
    } state_t;

    // arctangent of 2^-i in Q16 degrees
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [3:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            4'd0:    v = ANG_W'(2949120);
            4'd1:    v = ANG_W'(1740967);
            4'd2:    v = ANG_W'(919879);
            4'd3:    v = ANG_W'(466945);
            4'd4:    v = ANG_W'(234379);
            4'd5:    v = ANG_W'(117265);
            4'd6:    v = ANG_W'(58666);
            4'd7:    v = ANG_W'(29335);
            4'd8:    v = ANG_W'(14668);
            4'd9:    v = ANG_W'(7334);
            4'd10:   v = ANG_W'(3667);
            4'd11:   v = ANG_W'(1833);
            4'd12:   v = ANG_W'(917);
            4'd13:   v = ANG_W'(458);
            4'd14:   v = ANG_W'(229);
            4'd15:   v = ANG_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

    // stored code to map value
    function automatic logic signed [VAL_W-1:0] code_to_value(input logic [1:0] code);
        logic signed [VAL_W-1:0] v;
        case (code)
            CODE_FREE:     v = VAL_W'(0);
            CODE_OCCUPIED: v = VAL_W'(100);
            default:       v = -VAL_W'(1);
        endcase
        return v;
    endfunction

endpackage

[rtl/ogp_if.sv]
interface ogp_in_if import ogp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [PIX_W-1:0]    pixel_column;
    logic [PIX_W-1:0]    pixel_row;
    logic                depth_valid;
    logic [DEPTH_W-1:0]  depth_q10;
    logic [BYTE_W-1:0]   label_blue;
    logic [BYTE_W-1:0]   label_green;
    logic [BYTE_W-1:0]   label_red;
    logic [MAPI_W-1:0]   map_index;

    modport source (output valid, func, pixel_column, pixel_row, depth_valid, depth_q10,
                    label_blue, label_green, label_red, map_index, input ready);
    modport sink (input valid, func, pixel_column, pixel_row, depth_valid, depth_q10,
                  label_blue, label_green, label_red, map_index, output ready);
endinterface

interface ogp_out_if import ogp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] cell_value;

    modport source (output valid, cell_value, input ready);
    modport sink (input valid, cell_value, output ready);
endinterface

[rtl/ogp_cfg.sv]
module ogp_cfg import ogp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[CFG_AW-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fovh      <= 8'd120;
            cfg_reg.fovv      <= 8'd70;
            cfg_reg.pitch     <= 7'd10;
            cfg_reg.cols      <= 10'd513;
            cfg_reg.rows      <= 10'd288;
            cfg_reg.cpm       <= 16'd5120;
            cfg_reg.max_depth <= 16'd15360;
        end
        else if (wr)
        begin
            case (idx)
                REG_FOVH:  cfg_reg.fovh      <= pwdata[7:0];
                REG_FOVV:  cfg_reg.fovv      <= pwdata[7:0];
                REG_PITCH: cfg_reg.pitch     <= pwdata[6:0];
                REG_COLS:  cfg_reg.cols      <= pwdata[PIX_W-1:0];
                REG_ROWS:  cfg_reg.rows      <= pwdata[PIX_W-1:0];
                REG_CPM:   cfg_reg.cpm       <= pwdata[15:0];
                REG_MAXD:  cfg_reg.max_depth <= pwdata[DEPTH_W-1:0];
                default:   ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            REG_FOVH:  prdata = CFG_DW'(cfg_reg.fovh);
            REG_FOVV:  prdata = CFG_DW'(cfg_reg.fovv);
            REG_PITCH: prdata = CFG_DW'(cfg_reg.pitch);
            REG_COLS:  prdata = CFG_DW'(cfg_reg.cols);
            REG_ROWS:  prdata = CFG_DW'(cfg_reg.rows);
            REG_CPM:   prdata = CFG_DW'(cfg_reg.cpm);
            REG_MAXD:  prdata = CFG_DW'(cfg_reg.max_depth);
            default:   prdata = '0;
        endcase
    end

endmodule

[rtl/ogp_div.sv]
module ogp_div import ogp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign done      = done_reg;
    assign quotient  = quo_reg;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

[rtl/ogp_cordic.sv]
module ogp_cordic import ogp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ANG_W-1:0]  angle,
    output logic                     done,
    output logic signed [TRIG_W-1:0] sin_q30,
    output logic signed [TRIG_W-1:0] cos_q30
);

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360 * 65536);

    logic                    busy_reg, done_reg;
    logic [3:0]              cnt_reg;
    logic                    flip_reg;
    logic signed [XY_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [ANG_W-1:0] a_wrap, a_fold;
    logic                    flip;
    logic signed [XY_W-1:0]  dx, dy, sin_x, cos_x;

    // wrap into (-180,180] and fold into [-90,90]
    always_comb
    begin
        a_wrap = angle;
        if (a_wrap <= -DEG180)
        begin
            a_wrap = a_wrap + DEG360;
        end
        if (a_wrap > DEG180)
        begin
            a_wrap = a_wrap - DEG360;
        end
        flip   = 1'b0;
        a_fold = a_wrap;
        if (a_wrap > DEG90)
        begin
            a_fold = a_wrap - DEG180;
            flip   = 1'b1;
        end
        else if (a_wrap < -DEG90)
        begin
            a_fold = a_wrap + DEG180;
            flip   = 1'b1;
        end
    end

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one rotation step per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= a_fold;
            flip_reg <= flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_q16(cnt_reg);
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_q16(cnt_reg);
            end
        end
    end

    assign sin_x   = flip_reg ? -y_reg : y_reg;
    assign cos_x   = flip_reg ? -x_reg : x_reg;
    assign sin_q30 = TRIG_W'(sin_x);
    assign cos_q30 = TRIG_W'(cos_x);
    assign done    = done_reg;

endmodule

[rtl/ogp_grid.sv]
module ogp_grid import ogp_pkg::*;
#(
    parameter int CELLS  = 262144,
    parameter int ADDR_W = 18
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  grid_cmd_t         cmd,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [1:0]        rd_code,
    output logic              busy
);

    logic [1:0]        mem [CELLS];
    logic              sweep_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic [1:0]        rd_code_reg;

    assign busy    = sweep_reg;
    assign rd_code = rd_code_reg;

    // clearing pass, one entry per cycle, also run after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else if (sweep_reg)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
            if (sweep_cnt_reg == ADDR_W'(CELLS - 1))
            begin
                sweep_reg <= 1'b0;
            end
        end
    end

    // grid store
    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            mem[sweep_cnt_reg] <= CODE_UNKNOWN;
        end
        else if (cmd.wr_en)
        begin
            mem[wr_addr] <= cmd.wr_code;
        end
        if (cmd.rd_en)
        begin
            rd_code_reg <= mem[rd_addr];
        end
    end

endmodule

[rtl/depth_pixel_to_occupancy_grid_core.sv]
// Occupancy grid of GRID_SIDE x GRID_SIDE cells held in one synchronous memory (2 bits a
// cell), fed by segmented depth pixels. Items are taken one at a time. A pixel that counts
// goes through the accepting cycle, two 34-step serial divisions for the angles, a 16-step
// CORDIC for the pitch angle (the heading CORDIC overlaps the second division), the
// multiply states on the shared multiplier and three grid writes; a pixel that does not
// count is dropped. A map read reads the memory as it is taken, then passes ST_RD_LAT and
// ST_RD_OUT (no ST_RD_LAT for an index past the grid) and waits in ST_RD_OUT while an
// earlier value still sits in the output register; row and column come from a shift and
// a mask of the index. A clear, and reset, start a clearing pass over GRID_SIDE*GRID_SIDE
// cells (262144 at the default size) during which no item is taken; configuration writes
// are taken at any time but should only be made while no item is in flight. One result
// register on the output lets the block go on while a read value waits to be taken.
module depth_pixel_to_occupancy_grid_core import ogp_pkg::*;
#(
    parameter int GRID_SIDE = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    ogp_in_if.sink            in_ch,
    ogp_out_if.source         out_ch
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(GRID_SIDE);
    localparam int HALF   = GRID_SIDE / 2;
    localparam logic signed [OFF_W-1:0]  HALF_S = OFF_W'(HALF);
    localparam logic signed [PROD_W-1:0] TRUNC_ADJ = (PROD_W'(1) <<< 48) - PROD_W'(1);

    cfg_t cfg;

    state_t state_reg, state_next;

    // item and datapath registers
    logic [PIX_W-1:0]          row_reg;
    logic [DEPTH_W-1:0]        depth_reg;
    logic [1:0]                code_reg;
    logic signed [ANG_W-1:0]   theta_reg;
    logic signed [TRIG_W-1:0]  sth_reg, cth_reg, cph_reg;
    logic [SCALE_W-1:0]        scale_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [XY_W-1:0]    cx_reg, cy_reg;
    logic signed [OFF_W-1:0]   ox_reg, oy_reg;
    logic [1:0]                k_reg;
    logic [1:0]                res_reg;
    logic                      out_valid_reg;
    logic signed [VAL_W-1:0]   out_value_reg;

    // control outputs
    logic                      accept;
    logic                      pix_ok;
    logic [1:0]                pix_code;
    logic                      pix_class;
    logic                      read_in_range;
    logic                      div_start, div_done;
    logic [DVD_W-1:0]          div_dividend, div_q;
    logic [DVS_W-1:0]          div_divisor;
    logic                      cor_start, cor_done;
    logic signed [ANG_W-1:0]   cor_angle, phi, theta;
    logic signed [TRIG_W-1:0]  cor_sin, cor_cos;
    grid_cmd_t                 gcmd;
    logic [ADDR_W-1:0]         wr_addr, rd_addr;
    logic [1:0]                rd_code;
    logic                      grid_busy;
    logic                      out_load;
    logic                      out_free;
    logic signed [XY_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [OFF_W-1:0]   trunc_off;
    logic signed [POS_W-1:0]   row_s, col_s;
    logic                      wr_ok;
    logic [IDX_W-1:0]          rd_row, rd_col;

    ogp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ogp_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q)
    );

    ogp_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .sin_q30 (cor_sin),
        .cos_q30 (cor_cos)
    );

    ogp_grid #(.CELLS(CELLS), .ADDR_W(ADDR_W)) u_grid
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (gcmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_code (rd_code),
        .busy    (grid_busy)
    );

    // pixel class and acceptance tests
    always_comb
    begin
        pix_class = 1'b0;
        pix_code  = CODE_UNKNOWN;
        if (in_ch.label_blue == '0 && in_ch.label_green == '0)
        begin
            if (in_ch.label_red == 8'd64 || in_ch.label_red == 8'd192)
            begin
                pix_class = 1'b1;
                pix_code  = CODE_OCCUPIED;
            end
            else if (in_ch.label_red == 8'd0 || in_ch.label_red == 8'd128)
            begin
                pix_class = 1'b1;
                pix_code  = CODE_FREE;
            end
        end
        pix_ok = pix_class
              && in_ch.pixel_column < cfg.cols
              && in_ch.pixel_row >= (cfg.rows >> 1)
              && in_ch.pixel_row < cfg.rows
              && in_ch.depth_valid
              && in_ch.depth_q10 <= cfg.max_depth;
        read_in_range = 32'(in_ch.map_index) < 32'(CELLS);
    end

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // heading angle from the first quotient
    assign theta = $signed({2'b00, div_q[24:0]}) - $signed({4'b0000, cfg.fovh, 15'd0});

    // pitch angle from the second quotient
    assign phi = $signed({2'b00, div_q[24:0]}) - $signed({4'b0000, cfg.fovv, 15'd0})
               - $signed({4'b0000, cfg.pitch, 16'd0});

    // truncation of the Q48 product toward zero
    always_comb
    begin
        if (prod_reg[PROD_W-1])
        begin
            trunc_off = OFF_W'((prod_reg + TRUNC_ADJ) >>> 48);
        end
        else
        begin
            trunc_off = OFF_W'(prod_reg >>> 48);
        end
    end

    // grid position of the current write
    always_comb
    begin
        row_s = POS_W'(HALF) - POS_W'(oy_reg) + POS_W'(k_reg);
        col_s = POS_W'(HALF) + POS_W'(ox_reg);
        wr_ok = oy_reg <= HALF_S && ox_reg >= -HALF_S && ox_reg <= HALF_S
             && !row_s[POS_W-1] && row_s < POS_W'(GRID_SIDE)
             && !col_s[POS_W-1] && col_s < POS_W'(GRID_SIDE);
        wr_addr = ADDR_W'(row_s[IDX_W-1:0]) * ADDR_W'(GRID_SIDE) + ADDR_W'(col_s[IDX_W-1:0]);
    end

    // read position, rows and columns reversed
    assign rd_col  = IDX_W'(GRID_SIDE - 1) - IDX_W'(in_ch.map_index >> IDX_W);
    assign rd_row  = IDX_W'(GRID_SIDE - 1) - in_ch.map_index[IDX_W-1:0];
    assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(rd_col);

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            ST_MUL1:
            begin
                mul_a = XY_W'(cph_reg);
                mul_b = XY_W'(sth_reg);
            end
            ST_MUL2:
            begin
                mul_a = XY_W'(cph_reg);
                mul_b = XY_W'(cth_reg);
            end
            ST_MUL3:
            begin
                mul_a = $signed({1'b0, scale_reg});
                mul_b = cx_reg;
            end
            default:
            begin
                mul_a = $signed({1'b0, scale_reg});
                mul_b = cy_reg;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR_GO: state_next = ST_CLEAR;
            ST_CLEAR:
            begin
                if (!grid_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.func)
                        FUNC_PIXEL: state_next = pix_ok ? ST_TH_DIV : ST_IDLE;
                        FUNC_CLEAR: state_next = ST_CLR_GO;
                        FUNC_READ:  state_next = read_in_range ? ST_RD_LAT : ST_RD_OUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TH_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PH_DIV;
                end
            end
            ST_PH_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PH_COR;
                end
            end
            ST_PH_COR:
            begin
                if (cor_done)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_MUL4;
            ST_MUL4:   state_next = ST_MUL5;
            ST_MUL5:   state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_LAT: state_next = ST_RD_OUT;
            ST_RD_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ch.ready  = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = {1'b0, cfg.cols};
        cor_start    = 1'b0;
        cor_angle    = theta_reg;
        gcmd         = '0;
        gcmd.wr_code = code_reg;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid && in_ch.func == FUNC_PIXEL)
                begin
                    div_start    = pix_ok;
                    div_dividend = {18'(in_ch.pixel_column) * 18'(cfg.fovh), 16'd0};
                    div_divisor  = {1'b0, cfg.cols};
                end
                else if (in_ch.valid && in_ch.func == FUNC_READ)
                begin
                    gcmd.rd_en = read_in_range;
                end
            end
            ST_CLR_GO:
            begin
                gcmd.clear = 1'b1;
            end
            ST_TH_DIV:
            begin
                div_dividend = {18'(row_reg) * 18'(cfg.fovv), 16'd0};
                div_divisor  = {1'b0, cfg.rows};
                div_start    = div_done;
                cor_angle    = theta;
                cor_start    = div_done;
            end
            ST_PH_DIV:
            begin
                cor_angle = phi;
                cor_start = div_done;
            end
            ST_WRITE:
            begin
                gcmd.wr_en = wr_ok;
            end
            ST_RD_OUT:
            begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            row_reg   <= in_ch.pixel_row;
            depth_reg <= in_ch.depth_q10;
            code_reg  <= pix_code;
            res_reg   <= CODE_UNKNOWN;
        end
        // heading angle, its CORDIC runs during the pitch division
        if (state_reg == ST_TH_DIV && div_done)
        begin
            theta_reg <= theta;
        end
        if (state_reg == ST_PH_DIV && cor_done)
        begin
            sth_reg <= cor_sin;
            cth_reg <= cor_cos;
        end
        if (state_reg == ST_PH_COR && cor_done)
        begin
            cph_reg   <= cor_cos;
            scale_reg <= SCALE_W'(depth_reg * cfg.cpm);
        end
        case (state_reg)
            ST_MUL1: prod_reg <= mul_p;
            ST_MUL2:
            begin
                cx_reg   <= XY_W'(prod_reg >>> 30);
                prod_reg <= mul_p;
            end
            ST_MUL3:
            begin
                cy_reg   <= XY_W'(prod_reg >>> 30);
                prod_reg <= mul_p;
            end
            ST_MUL4:
            begin
                ox_reg   <= trunc_off;
                prod_reg <= mul_p;
            end
            ST_MUL5:
            begin
                oy_reg <= trunc_off;
                k_reg  <= 2'd0;
            end
            ST_WRITE:  k_reg   <= k_reg + 2'd1;
            ST_RD_LAT: res_reg <= rd_code;
            default: ;
        endcase
        if (out_load)
        begin
            out_value_reg <= code_to_value(res_reg);
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.cell_value = out_value_reg;

endmodule
